// ===== rtl/vector3_arithmetic_unit_defines.svh =====
// Assertion macros for the vector unit
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
// assert that a implies b in the next cycle
`define V3_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// assert that a implies b in the same cycle
`define V3_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/v3au_pkg.sv =====
`timescale 1ns / 1ps
package v3au_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 32;
  // capture, products, simple results, squares, sum, root steps, quotient steps, output
  localparam int LAT = 6 + SQRT_STEPS + DIV_STEPS;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_SCALE = 3'd2, OP_DIV = 3'd3,
    OP_CROSS = 3'd4, OP_DOT = 3'd5, OP_NORM = 3'd6, OP_CMP = 3'd7
  } op_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] dot;
    logic        eq;
    logic        err;
  } res_t;

  function automatic logic [31:0] sat32(input logic signed [95:0] v, output logic e);
    e = 1'b0;
    if (v > 96'sd2147483647) begin
      e = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -96'sd2147483648) begin
      e = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction
endpackage

// ===== rtl/v3au_core.sv =====
`timescale 1ns / 1ps
`include "vector3_arithmetic_unit_defines.svh"
module v3au_core import v3au_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_i,
  input  op_t         op_i,
  input  logic signed [31:0] ax, ay, az, bx, by, bz, sv,
  output logic        vld_o,
  output res_t        res_o
);
  // word state carried down the root and quotient pipes
  typedef struct packed {
    res_t             res;
    logic             dv;   // divide by a nonzero scalar
    logic             nm;   // normalize of a nonzero vector
    logic [2:0]       ovf;
    logic [2:0]       neg;
    logic [31:0]      den;
    logic [2:0][31:0] mag;
  } carry_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqs_t;

  typedef struct packed {
    logic [2:0][63:0] rem;
    logic [2:0][31:0] q;
  } div_t;

  // left shift that brings the largest magnitude to at least 2^30
  function automatic logic [4:0] lead_shift(input logic [31:0] v);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i < 30; i++)
      if (v[i]) k = 5'(30 - i);
    if (v[31:30] != 2'b00) k = '0;
    return k;
  endfunction

  function automatic sqs_t sqrt_step(input sqs_t v, input int j);
    sqs_t o;
    logic [63:0] bitv, trial;
    bitv = 64'd1 << (62 - 2 * j);
    trial = v.root + bitv;
    if (v.rem >= trial) begin
      o.rem = v.rem - trial;
      o.root = (v.root >> 1) + bitv;
    end else begin
      o.rem = v.rem;
      o.root = v.root >> 1;
    end
    return o;
  endfunction

  // one restoring quotient bit per lane, most significant first
  function automatic div_t div_step(input div_t v, input logic [31:0] den, input int j);
    div_t o;
    logic [63:0] sub;
    sub = 64'(den) << (31 - j);
    for (int l = 0; l < 3; l++) begin
      if (v.rem[l] >= sub) begin
        o.rem[l] = v.rem[l] - sub;
        o.q[l] = {v.q[l][30:0], 1'b1};
      end else begin
        o.rem[l] = v.rem[l];
        o.q[l] = {v.q[l][30:0], 1'b0};
      end
    end
    return o;
  endfunction

  // stage 1: capture
  logic [LAT-1:0] vld_r;
  op_t op_r;
  logic signed [31:0] a_r [3];
  logic signed [31:0] b_r [3];
  logic signed [31:0] s_r;
  // stage 2: products
  op_t op2_r;
  logic signed [63:0] p_r [6];
  logic signed [31:0] a2_r [3];
  logic signed [31:0] b2_r [3];
  logic signed [31:0] s2_r;
  logic [31:0] mag2_r [3];
  logic [31:0] smag2_r;
  res_t res_r, res_nxt;
  // stages 3 to 5: simple results, squares, sum of squares
  logic [31:0] mag_or;
  logic [4:0] nsh;
  carry_t c_nxt, c_car_r, d_nxt, d_car_r, e_car_r;
  logic [63:0] sqr_r [3];
  logic [63:0] sum_r;
  // root and quotient pipes
  sqs_t rt_in;
  sqs_t rt_r [SQRT_STEPS];
  sqs_t rt_nxt [SQRT_STEPS];
  carry_t rtc_r [SQRT_STEPS];
  carry_t dvc0;
  div_t dv_in;
  div_t dv_r [DIV_STEPS];
  div_t dv_nxt [DIV_STEPS];
  carry_t dvc_r [DIV_STEPS];
  res_t fin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LAT-2:0], vld_i};
  end

  always_ff @(posedge clk) begin
    op_r <= op_i;
    a_r[0] <= ax; a_r[1] <= ay; a_r[2] <= az;
    b_r[0] <= bx; b_r[1] <= by; b_r[2] <= bz;
    s_r <= sv;
    op2_r <= op_r;
    a2_r <= a_r; b2_r <= b_r; s2_r <= s_r;
    for (int i = 0; i < 3; i++)
      mag2_r[i] <= a_r[i][31] ? $unsigned(-a_r[i]) : $unsigned(a_r[i]);
    smag2_r <= s_r[31] ? $unsigned(-s_r) : $unsigned(s_r);
    case (op_r)
      OP_SCALE: begin
        p_r[0] <= a_r[0] * s_r; p_r[1] <= a_r[1] * s_r; p_r[2] <= a_r[2] * s_r;
        p_r[3] <= '0; p_r[4] <= '0; p_r[5] <= '0;
      end
      OP_CROSS: begin
        p_r[0] <= a_r[1] * b_r[2]; p_r[1] <= a_r[2] * b_r[1];
        p_r[2] <= a_r[2] * b_r[0]; p_r[3] <= a_r[0] * b_r[2];
        p_r[4] <= a_r[0] * b_r[1]; p_r[5] <= a_r[1] * b_r[0];
      end
      default: begin
        p_r[0] <= a_r[0] * b_r[0]; p_r[1] <= a_r[1] * b_r[1];
        p_r[2] <= a_r[2] * b_r[2];
        p_r[3] <= '0; p_r[4] <= '0; p_r[5] <= '0;
      end
    endcase
  end

  // floor of exact sum equals arithmetic shift of wide sum
  always_comb begin
    logic e0, e1, e2;
    logic signed [95:0] w0, w1, w2;
    res_nxt = '0;
    e0 = 1'b0; e1 = 1'b0; e2 = 1'b0;
    w0 = '0; w1 = '0; w2 = '0;
    case (op2_r)
      OP_ADD: begin
        w0 = 96'(a2_r[0]) + 96'(b2_r[0]);
        w1 = 96'(a2_r[1]) + 96'(b2_r[1]);
        w2 = 96'(a2_r[2]) + 96'(b2_r[2]);
        res_nxt.x = sat32(w0, e0); res_nxt.y = sat32(w1, e1); res_nxt.z = sat32(w2, e2);
      end
      OP_SUB: begin
        w0 = 96'(a2_r[0]) - 96'(b2_r[0]);
        w1 = 96'(a2_r[1]) - 96'(b2_r[1]);
        w2 = 96'(a2_r[2]) - 96'(b2_r[2]);
        res_nxt.x = sat32(w0, e0); res_nxt.y = sat32(w1, e1); res_nxt.z = sat32(w2, e2);
      end
      OP_SCALE: begin
        w0 = 96'(p_r[0]) >>> FRAC_BITS;
        w1 = 96'(p_r[1]) >>> FRAC_BITS;
        w2 = 96'(p_r[2]) >>> FRAC_BITS;
        res_nxt.x = sat32(w0, e0); res_nxt.y = sat32(w1, e1); res_nxt.z = sat32(w2, e2);
      end
      OP_CROSS: begin
        w0 = (96'(p_r[0]) - 96'(p_r[1])) >>> FRAC_BITS;
        w1 = (96'(p_r[2]) - 96'(p_r[3])) >>> FRAC_BITS;
        w2 = (96'(p_r[4]) - 96'(p_r[5])) >>> FRAC_BITS;
        res_nxt.x = sat32(w0, e0); res_nxt.y = sat32(w1, e1); res_nxt.z = sat32(w2, e2);
      end
      OP_DOT: begin
        w0 = (96'(p_r[0]) + 96'(p_r[1]) + 96'(p_r[2])) >>> FRAC_BITS;
        res_nxt.dot = sat32(w0, e0);
      end
      OP_CMP: res_nxt.eq = (a2_r[0] == b2_r[0]) && (a2_r[1] == b2_r[1]) &&
                           (a2_r[2] == b2_r[2]);
      OP_DIV: e0 = (s2_r == 0);
      default: ;
    endcase
    res_nxt.err = e0 | e1 | e2;
  end

  // the largest magnitude sets the common shift, so OR the magnitudes
  assign mag_or = mag2_r[0] | mag2_r[1] | mag2_r[2];
  assign nsh = lead_shift(mag_or);

  always_comb begin
    c_nxt.res = res_nxt;
    c_nxt.dv = (op2_r == OP_DIV) && (s2_r != 0);
    c_nxt.nm = (op2_r == OP_NORM) && (mag_or != 0);
    c_nxt.ovf = '0;
    c_nxt.den = smag2_r;
    for (int i = 0; i < 3; i++) begin
      if (op2_r == OP_DIV) begin
        c_nxt.neg[i] = a2_r[i][31] ^ s2_r[31];
        c_nxt.mag[i] = mag2_r[i];
      end else begin
        c_nxt.neg[i] = a2_r[i][31];
        c_nxt.mag[i] = mag2_r[i] << nsh;
      end
    end
  end

  // quotient needs more than 32 bits when the numerator reaches den * 2^32
  always_comb begin
    d_nxt = c_car_r;
    for (int l = 0; l < 3; l++)
      d_nxt.ovf[l] = (64'(c_car_r.mag[l]) << FRAC_BITS) >= {c_car_r.den, 32'd0};
  end

  always_ff @(posedge clk) begin
    c_car_r <= c_nxt;
    d_car_r <= d_nxt;
    for (int l = 0; l < 3; l++) sqr_r[l] <= c_car_r.mag[l] * c_car_r.mag[l];
    e_car_r <= d_car_r;
    sum_r <= sqr_r[0] + sqr_r[1] + sqr_r[2];
  end

  always_comb begin
    rt_in.rem = sum_r;
    rt_in.root = '0;
    rt_nxt[0] = sqrt_step(rt_in, 0);
    for (int j = 1; j < SQRT_STEPS; j++) rt_nxt[j] = sqrt_step(rt_r[j-1], j);
  end

  always_ff @(posedge clk) begin
    rt_r <= rt_nxt;
    rtc_r[0] <= e_car_r;
    for (int j = 1; j < SQRT_STEPS; j++) rtc_r[j] <= rtc_r[j-1];
  end

  // normalize divides by the root, divide by the scalar magnitude
  always_comb begin
    dvc0 = rtc_r[SQRT_STEPS-1];
    if (dvc0.nm) dvc0.den = rt_r[SQRT_STEPS-1].root[31:0];
    for (int l = 0; l < 3; l++) begin
      dv_in.rem[l] = 64'(dvc0.mag[l]) << FRAC_BITS;
      dv_in.q[l] = '0;
    end
    dv_nxt[0] = div_step(dv_in, dvc0.den, 0);
    for (int j = 1; j < DIV_STEPS; j++) dv_nxt[j] = div_step(dv_r[j-1], dvc_r[j-1].den, j);
  end

  always_ff @(posedge clk) begin
    dv_r <= dv_nxt;
    dvc_r[0] <= dvc0;
    for (int j = 1; j < DIV_STEPS; j++) dvc_r[j] <= dvc_r[j-1];
  end

  // apply sign, saturate divide results
  always_comb begin
    carry_t fc;
    logic [31:0] q;
    logic sat;
    logic [2:0][31:0] lane;
    fc = dvc_r[DIV_STEPS-1];
    fin_nxt = fc.res;
    for (int l = 0; l < 3; l++) begin
      q = dv_r[DIV_STEPS-1].q[l];
      sat = fc.dv && (fc.ovf[l] || (fc.neg[l] ? (q > 32'h80000000) : q[31]));
      if (sat) begin
        lane[l] = fc.neg[l] ? 32'h80000000 : 32'h7fffffff;
        fin_nxt.err = 1'b1;
      end else begin
        lane[l] = fc.neg[l] ? -q : q;
      end
    end
    if (fc.dv || fc.nm) begin
      fin_nxt.x = lane[0];
      fin_nxt.y = lane[1];
      fin_nxt.z = lane[2];
    end
  end

  always_ff @(posedge clk) res_r <= fin_nxt;

  assign vld_o = vld_r[LAT-1];
  assign res_o = res_r;

  `V3_ASSERT_NEXT(a_vld_adv, clk, rst_n, vld_r[0], vld_r[1])
  `V3_ASSERT_NOW(a_eq_cmp, clk, rst_n, vld_o && res_o.eq, res_o.x == 0 && !res_o.err)
  `V3_ASSERT_NOW(a_dot_only, clk, rst_n, vld_o && res_o.dot != 0, res_o.x == 0)
endmodule

// ===== rtl/vector3_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Vector unit, signed fixed point.
// Every opcode takes the same path from start to out_valid.
// Throughput: one word per cycle; busy stays low, the receiver cannot stall.
// Latency set by the 32-step square-root pipe for normalize feeding the 32-step divider.
// Reset (rst_n low, synchronous) clears the valid pipe only.
module vector3_arithmetic_unit import v3au_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [2:0] in_operation,
  input  logic signed [31:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z,
  input  logic signed [31:0] in_scale_value,
  output logic out_valid,
  output logic signed [31:0] out_r_x, out_r_y, out_r_z, out_dot_result,
  output logic out_equal_flag,
  output logic out_error_flag
);
  res_t res;
  assign busy = 1'b0;
  v3au_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .vld_i(start), .op_i(op_t'(in_operation)),
    .ax(in_a_x), .ay(in_a_y), .az(in_a_z), .bx(in_b_x), .by(in_b_y), .bz(in_b_z),
    .sv(in_scale_value), .vld_o(out_valid), .res_o(res)
  );
  assign out_r_x = res.x;
  assign out_r_y = res.y;
  assign out_r_z = res.z;
  assign out_dot_result = res.dot;
  assign out_equal_flag = res.eq;
  assign out_error_flag = res.err;
endmodule
